>>> sv/stsc_pkg.sv
// shared types, constants and tables for the stick to world velocity command unit
package stsc_pkg;

   localparam int ANGLE_BITS_DEF = 16;
   localparam int QUEUE_DEPTH    = 2;

   localparam int STICK_W   = 12;
   localparam int OFS_W     = 11;
   localparam logic [STICK_W-1:0] STICK_MIN = 12'd1000;
   localparam logic [STICK_W-1:0] STICK_MAX = 12'd2000;
   localparam logic [STICK_W-1:0] STICK_MID = 12'd1500;

   // floor(m / 500) = (m * DIV500_K) >> DIV500_S for m < 2^24
   localparam int DIV500_S = 33;
   localparam logic [24:0] DIV500_K = 25'd17179870;
   // floor(m / 1000) = (m * DIV1000_K) >> DIV1000_S for m < 2^25
   localparam int DIV1000_S = 35;
   localparam logic [25:0] DIV1000_K = 26'd34359739;

   localparam int CORDIC_ITERS = 15;
   localparam logic signed [17:0] CORDIC_X0 = 18'sd19899;
   localparam logic signed [17:0] TRIG_MAX  = 18'sd32767;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_FORWARD_MAX  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_LATERAL_MAX  = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_VEL_VERTICAL_MAX = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_HEADING_GAIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_RATE_GAIN        = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_AUTO_YAW         = 3'd5;

   typedef struct packed {
      logic [14:0] vel_forward_max;
      logic [14:0] vel_lateral_max;
      logic [14:0] vel_vertical_max;
      logic [15:0] heading_gain;
      logic [15:0] rate_gain;
      logic        auto_yaw;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      vel_forward_max:  15'd7000,
      vel_lateral_max:  15'd5000,
      vel_vertical_max: 15'd3000,
      heading_gain:     16'd16384,
      rate_gain:        16'd41943,
      auto_yaw:         1'b1
   };

   typedef struct packed {
      logic signed [OFS_W-1:0] roll_ofs;
      logic signed [OFS_W-1:0] pitch_ofs;
      logic signed [OFS_W-1:0] throttle_ofs;
      logic signed [OFS_W-1:0] yaw_ofs;
      logic                    load_heading;
      logic [15:0]             heading_in;
   } cmd_type;

   typedef struct packed {
      logic signed [16:0] vel_world_x;
      logic signed [16:0] vel_world_y;
      logic signed [15:0] vel_world_z;
      logic signed [15:0] yaw_rate_cmd;
      logic [15:0]        heading_out;
   } rsp_type;

   // arctangent of 2^-i in 16-bit angle units
   function automatic logic [13:0] atan_of(input logic [3:0] i);
      logic [13:0] a;
      case (i)
         4'd0:    a = 14'd8192;
         4'd1:    a = 14'd4836;
         4'd2:    a = 14'd2555;
         4'd3:    a = 14'd1297;
         4'd4:    a = 14'd651;
         4'd5:    a = 14'd326;
         4'd6:    a = 14'd163;
         4'd7:    a = 14'd81;
         4'd8:    a = 14'd41;
         4'd9:    a = 14'd20;
         4'd10:   a = 14'd10;
         4'd11:   a = 14'd5;
         4'd12:   a = 14'd3;
         4'd13:   a = 14'd1;
         4'd14:   a = 14'd1;
         default: a = 14'd0;
      endcase
      return a;
   endfunction

endpackage

>>> sv/stsc_fifo.sv
// small first-in first-out queue with show-ahead read
module stsc_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = stsc_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in;
   logic [AW-1:0]    rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full     = (cnt_ff == CW'(DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

>>> sv/stsc_front.sv
// front end: accepts stick beats, clamps and centers the pulse widths
module stsc_front (
   input  logic                  push,
   output logic                  full,
   input  logic [11:0]           roll_stick,
   input  logic [11:0]           pitch_stick,
   input  logic [11:0]           throttle_stick,
   input  logic [11:0]           yaw_stick,
   input  logic                  load_heading,
   input  logic [15:0]           heading_in,
   output logic                  q_push,
   output stsc_pkg::cmd_type     q_data,
   input  logic                  q_full
);
   import stsc_pkg::*;

   function automatic logic signed [OFS_W-1:0] center(input logic [STICK_W-1:0] raw);
      logic [STICK_W-1:0] c;
      logic [STICK_W-1:0] d;
      c = raw;
      if (raw < STICK_MIN) begin
         c = STICK_MIN;
      end else if (raw > STICK_MAX) begin
         c = STICK_MAX;
      end
      d = c - STICK_MID;
      return $signed(d[OFS_W-1:0]);
   endfunction

   assign full   = q_full;
   assign q_push = push && !q_full;

   always_comb begin
      q_data.roll_ofs     = center(roll_stick);
      q_data.pitch_ofs    = center(pitch_stick);
      q_data.throttle_ofs = center(throttle_stick);
      q_data.yaw_ofs      = center(yaw_stick);
      q_data.load_heading = load_heading;
      q_data.heading_in   = heading_in;
   end

endmodule

>>> sv/stsc_back.sv
// back end: scaling, heading update, iterative cordic and rotation to world frame
module stsc_back #(
   parameter int ANGLE_BITS = stsc_pkg::ANGLE_BITS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  stsc_pkg::cfg_type cfg,
   input  logic              cmd_empty,
   output logic              cmd_pop,
   input  stsc_pkg::cmd_type cmd_data,
   input  logic              rsp_full,
   output logic              rsp_push,
   output stsc_pkg::rsp_type rsp_data
);
   import stsc_pkg::*;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_HEAD = 3'd3;
   localparam logic [2:0] ST_CORD = 3'd4;
   localparam logic [2:0] ST_FIN  = 3'd5;
   localparam logic [2:0] ST_ROT  = 3'd6;
   localparam logic [2:0] ST_SUM  = 3'd7;

   typedef struct packed {
      logic signed [17:0] x;
      logic signed [17:0] y;
      logic signed [16:0] z;
   } rot_type;

   function automatic rot_type cordic_step(input rot_type v, input logic [3:0] i);
      rot_type            r;
      logic signed [17:0] dx;
      logic signed [17:0] dy;
      logic signed [16:0] a;
      dx = v.y >>> i;
      dy = v.x >>> i;
      a  = $signed({3'b000, atan_of(i)});
      if (!v.z[16]) begin
         r.x = v.x - dx;
         r.y = v.y + dy;
         r.z = v.z - a;
      end else begin
         r.x = v.x + dx;
         r.y = v.y - dy;
         r.z = v.z + a;
      end
      return r;
   endfunction

   function automatic logic signed [15:0] apply_sign(input logic neg, input logic [14:0] q);
      logic signed [15:0] v;
      v = $signed({1'b0, q});
      return neg ? -v : v;
   endfunction

   function automatic logic signed [15:0] trig_sat(input logic neg, input logic signed [17:0] v);
      logic signed [17:0] n;
      logic signed [17:0] s;
      n = neg ? -v : v;
      s = n;
      if (n > TRIG_MAX) begin
         s = TRIG_MAX;
      end else if (n < -TRIG_MAX) begin
         s = -TRIG_MAX;
      end
      return s[15:0];
   endfunction

   function automatic logic signed [16:0] world_round(input logic signed [33:0] sum);
      logic signed [33:0] sh;
      logic signed [16:0] r;
      sh = (sum + 34'sd16384) >>> 15;
      r  = sh[16:0];
      if (sh > 34'sd65535) begin
         r = 17'sd65535;
      end else if (sh < -34'sd65536) begin
         r = -17'sd65536;
      end
      return r;
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [ANGLE_BITS-1:0] heading_ff, heading_in;
   logic [3:0]            iter_ff, iter_in;

   cmd_type            cmd_ff;
   logic [23:0]        m_fwd_ff, m_lat_ff, m_vert_ff;
   logic [24:0]        m_hdg_ff, m_rate_ff;
   logic signed [15:0] vx_ff, vy_ff, vz_ff, inc_ff, rate_ff;
   rot_type            rot_ff, rot_in;
   logic               neg_ff, neg_in;
   logic signed [15:0] cos_ff, sin_ff;
   logic signed [31:0] p_cx_ff, p_sy_ff, p_sx_ff, p_cy_ff;

   logic [8:0]         a_roll, a_pitch, a_thr, a_yaw;
   logic [48:0]        d_fwd, d_lat, d_vert;
   logic [50:0]        d_hdg, d_rate;
   logic [31:0]        hin32, inc32, hd32;
   logic [ANGLE_BITS-1:0] h_base, h_new;
   logic [ANGLE_BITS+15:0] h_win;
   logic [15:0]        a16;
   logic signed [16:0] z0;
   rot_type            step1, step2;
   logic [4:0]         iter_next;

   assign a_roll  = cmd_ff.roll_ofs[OFS_W-1]     ? 9'(-cmd_ff.roll_ofs)     : 9'(cmd_ff.roll_ofs);
   assign a_pitch = cmd_ff.pitch_ofs[OFS_W-1]    ? 9'(-cmd_ff.pitch_ofs)    : 9'(cmd_ff.pitch_ofs);
   assign a_thr   = cmd_ff.throttle_ofs[OFS_W-1] ? 9'(-cmd_ff.throttle_ofs) : 9'(cmd_ff.throttle_ofs);
   assign a_yaw   = cmd_ff.yaw_ofs[OFS_W-1]      ? 9'(-cmd_ff.yaw_ofs)      : 9'(cmd_ff.yaw_ofs);

   assign d_fwd  = m_fwd_ff * DIV500_K;
   assign d_lat  = m_lat_ff * DIV500_K;
   assign d_vert = m_vert_ff * DIV500_K;
   assign d_hdg  = m_hdg_ff * DIV1000_K;
   assign d_rate = m_rate_ff * DIV1000_K;

   // heading load, integration and cordic seed
   assign hin32  = 32'(cmd_ff.heading_in);
   assign inc32  = 32'(inc_ff);
   assign h_base = cmd_ff.load_heading ? hin32[ANGLE_BITS-1:0] : heading_ff;
   assign h_new  = cfg.auto_yaw ? h_base : h_base + inc32[ANGLE_BITS-1:0];
   assign h_win  = {h_new, 16'h0000};
   assign a16    = h_win[ANGLE_BITS+15:ANGLE_BITS];
   assign z0     = $signed({a16[15], a16});

   assign step1     = cordic_step(rot_ff, iter_ff);
   assign step2     = (iter_ff == 4'(CORDIC_ITERS - 1)) ? step1
                                                         : cordic_step(step1, iter_ff + 4'd1);
   assign iter_next = {1'b0, iter_ff} + 5'd2;

   assign cmd_pop  = (state_ff == ST_IDLE) && !cmd_empty;
   assign rsp_push = (state_ff == ST_SUM) && !rsp_full;
   assign hd32     = 32'(heading_ff);

   always_comb begin
      rsp_data.vel_world_x  = world_round(34'(p_cx_ff) - 34'(p_sy_ff));
      rsp_data.vel_world_y  = world_round(34'(p_sx_ff) + 34'(p_cy_ff));
      rsp_data.vel_world_z  = vz_ff;
      rsp_data.yaw_rate_cmd = rate_ff;
      rsp_data.heading_out  = hd32[15:0];
   end

   always_comb begin
      state_in   = state_ff;
      heading_in = heading_ff;
      iter_in    = iter_ff;
      rot_in     = rot_ff;
      neg_in     = neg_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!cmd_empty) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: state_in = ST_DIV;
         ST_DIV: state_in = ST_HEAD;
         ST_HEAD: begin
            heading_in = h_new;
            iter_in    = '0;
            rot_in.x   = CORDIC_X0;
            rot_in.y   = '0;
            rot_in.z   = z0;
            neg_in     = 1'b0;
            if (z0 > 17'sd16384) begin
               rot_in.z = z0 - 17'sd32768;
               neg_in   = 1'b1;
            end else if (z0 < -17'sd16384) begin
               rot_in.z = z0 + 17'sd32768;
               neg_in   = 1'b1;
            end
            state_in = ST_CORD;
         end
         ST_CORD: begin
            rot_in  = step2;
            iter_in = iter_next[3:0];
            if (iter_next >= 5'(CORDIC_ITERS)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: state_in = ST_ROT;
         ST_ROT: state_in = ST_SUM;
         ST_SUM: begin
            if (!rsp_full) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         heading_ff <= '0;
      end else begin
         state_ff   <= state_in;
         heading_ff <= heading_in;
      end
   end

   always_ff @(posedge clock) begin
      iter_ff <= iter_in;
      rot_ff  <= rot_in;
      neg_ff  <= neg_in;
      if (cmd_pop) begin
         cmd_ff <= cmd_data;
      end
      if (state_ff == ST_MUL) begin
         m_fwd_ff  <= a_pitch * cfg.vel_forward_max;
         m_lat_ff  <= a_roll * cfg.vel_lateral_max;
         m_vert_ff <= a_thr * cfg.vel_vertical_max;
         m_hdg_ff  <= a_yaw * cfg.heading_gain;
         m_rate_ff <= a_yaw * cfg.rate_gain;
      end
      if (state_ff == ST_DIV) begin
         vx_ff   <= apply_sign(cmd_ff.pitch_ofs[OFS_W-1], d_fwd[DIV500_S+14:DIV500_S]);
         vy_ff   <= apply_sign(!cmd_ff.roll_ofs[OFS_W-1], d_lat[DIV500_S+14:DIV500_S]);
         vz_ff   <= apply_sign(cmd_ff.throttle_ofs[OFS_W-1], d_vert[DIV500_S+14:DIV500_S]);
         inc_ff  <= apply_sign(cmd_ff.yaw_ofs[OFS_W-1], d_hdg[DIV1000_S+14:DIV1000_S]);
         rate_ff <= apply_sign(cmd_ff.yaw_ofs[OFS_W-1], d_rate[DIV1000_S+14:DIV1000_S]);
      end
      if (state_ff == ST_FIN) begin
         cos_ff <= trig_sat(neg_ff, rot_ff.x);
         sin_ff <= trig_sat(neg_ff, rot_ff.y);
      end
      if (state_ff == ST_ROT) begin
         p_cx_ff <= cos_ff * vx_ff;
         p_sy_ff <= sin_ff * vy_ff;
         p_sx_ff <= sin_ff * vx_ff;
         p_cy_ff <= cos_ff * vy_ff;
      end
   end

endmodule

>>> sv/stick_to_world_velocity_command_unit.sv
// top level of the stick to world velocity command unit
//
//  channel  ports                      direction  handshake
//  req      push / full + req_*        in         beat on push && !full
//  rsp      empty / pop + rsp_*        out        beat on pop && !empty
//  csr      csr_valid / csr_ready      in         write on csr_valid && csr_ready
//
// the back end works on one item at a time: pop, scale, divide, heading update,
// cordic at two rotations per cycle (one in its last step), then saturate, rotate and round
// reset clears both queues, the heading and loads the register defaults
// full rises when the two-entry input queue is held; the back end waits in its
// last step while the result queue is full
module stick_to_world_velocity_command_unit #(
   parameter int ANGLE_BITS = stsc_pkg::ANGLE_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               push,
   output logic                               full,
   input  logic [11:0]                        req_roll_stick,
   input  logic [11:0]                        req_pitch_stick,
   input  logic [11:0]                        req_throttle_stick,
   input  logic [11:0]                        req_yaw_stick,
   input  logic                               req_load_heading,
   input  logic [15:0]                        req_heading_in,
   output logic                               empty,
   input  logic                               pop,
   output logic signed [16:0]                 rsp_vel_world_x,
   output logic signed [16:0]                 rsp_vel_world_y,
   output logic signed [15:0]                 rsp_vel_world_z,
   output logic signed [15:0]                 rsp_yaw_rate_cmd,
   output logic [15:0]                        rsp_heading_out,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [stsc_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [stsc_pkg::CSR_DATA_W-1:0]    csr_data
);
   import stsc_pkg::*;

   cfg_type cfg_ff, cfg_in;
   cmd_type q_wdata, q_rdata;
   rsp_type b_rsp, o_rsp;
   logic    q_push, q_full, q_empty, q_pop;
   logic    b_push, o_full;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            REG_VEL_FORWARD_MAX:  cfg_in.vel_forward_max  = csr_data[14:0];
            REG_VEL_LATERAL_MAX:  cfg_in.vel_lateral_max  = csr_data[14:0];
            REG_VEL_VERTICAL_MAX: cfg_in.vel_vertical_max = csr_data[14:0];
            REG_HEADING_GAIN:     cfg_in.heading_gain     = csr_data[15:0];
            REG_RATE_GAIN:        cfg_in.rate_gain        = csr_data[15:0];
            REG_AUTO_YAW:         cfg_in.auto_yaw         = csr_data[0];
            default:              cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   stsc_front u_front (
      .push           (push),
      .full           (full),
      .roll_stick     (req_roll_stick),
      .pitch_stick    (req_pitch_stick),
      .throttle_stick (req_throttle_stick),
      .yaw_stick      (req_yaw_stick),
      .load_heading   (req_load_heading),
      .heading_in     (req_heading_in),
      .q_push         (q_push),
      .q_data         (q_wdata),
      .q_full         (q_full)
   );

   stsc_fifo #(
      .WIDTH ($bits(cmd_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_cmd_q (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_wdata),
      .full      (q_full),
      .pop       (q_pop),
      .pop_data  (q_rdata),
      .empty     (q_empty)
   );

   stsc_back #(
      .ANGLE_BITS (ANGLE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_empty (q_empty),
      .cmd_pop   (q_pop),
      .cmd_data  (q_rdata),
      .rsp_full  (o_full),
      .rsp_push  (b_push),
      .rsp_data  (b_rsp)
   );

   stsc_fifo #(
      .WIDTH ($bits(rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_q (
      .clock     (clock),
      .reset     (reset),
      .push      (b_push),
      .push_data (b_rsp),
      .full      (o_full),
      .pop       (pop),
      .pop_data  (o_rsp),
      .empty     (empty)
   );

   assign rsp_vel_world_x  = o_rsp.vel_world_x;
   assign rsp_vel_world_y  = o_rsp.vel_world_y;
   assign rsp_vel_world_z  = o_rsp.vel_world_z;
   assign rsp_yaw_rate_cmd = o_rsp.yaw_rate_cmd;
   assign rsp_heading_out  = o_rsp.heading_out;

endmodule

>>> dv/velocity_command_checker.sv
// checker that predicts and compares the velocity command results of the unit
module velocity_command_checker #(
   parameter int ANGLE_BITS = stsc_pkg::ANGLE_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            push,
   input  logic                            full,
   input  logic [11:0]                     req_roll_stick,
   input  logic [11:0]                     req_pitch_stick,
   input  logic [11:0]                     req_throttle_stick,
   input  logic [11:0]                     req_yaw_stick,
   input  logic                            req_load_heading,
   input  logic [15:0]                     req_heading_in,
   input  logic                            empty,
   input  logic                            pop,
   input  logic signed [16:0]              rsp_vel_world_x,
   input  logic signed [16:0]              rsp_vel_world_y,
   input  logic signed [15:0]              rsp_vel_world_z,
   input  logic signed [15:0]              rsp_yaw_rate_cmd,
   input  logic [15:0]                     rsp_heading_out,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [stsc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [stsc_pkg::CSR_DATA_W-1:0] csr_data,
   output int                              mismatches,
   output int                              outstanding,
   output int                              commands_seen,
   output int                              results_checked,
   output int                              writes_seen
);
   import stsc_pkg::*;

   localparam longint ANGLE_MASK = (longint'(1) << ANGLE_BITS) - 1;
   localparam longint STICK_HALF = 500;
   localparam longint GAIN_DIV   = 1000;
   localparam int ARCTAN [0:14] = '{8192, 4836, 2555, 1297, 651, 326, 163, 81,
                                    41, 20, 10, 5, 3, 1, 1};

   cfg_type settings = CFG_RESET;
   longint  heading_now = 0;
   rsp_type velocity_expected[$];
   int      fail_count = 0;
   int      accepted = 0;
   int      checked = 0;
   int      written = 0;

   function automatic longint clip(longint v, longint lo, longint hi);
      return (v < lo) ? lo : ((v > hi) ? hi : v);
   endfunction

   function automatic longint centered(logic [11:0] raw);
      longint v;
      v = longint'(raw);
      if (v < longint'(STICK_MIN)) v = longint'(STICK_MIN);
      if (v > longint'(STICK_MAX)) v = longint'(STICK_MAX);
      return v - longint'(STICK_MID);
   endfunction

   function automatic void heading_trig(input longint ang, output int c, output int s);
      int rs, ls, z, x, y, dx, dy, i;
      logic [15:0] a16;
      bit flip;
      rs = (ANGLE_BITS >= 16) ? ANGLE_BITS - 16 : 0;
      ls = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
      a16 = 16'((ang >> rs) << ls);
      z = (a16 >= 16'd32768) ? int'(a16) - 65536 : int'(a16);
      flip = 1'b0;
      x = int'(CORDIC_X0);
      y = 0;
      // fold into the right half plane
      if (z > 16384) begin
         z -= 32768;
         flip = 1'b1;
      end else if (z < -16384) begin
         z += 32768;
         flip = 1'b1;
      end
      for (i = 0; i < CORDIC_ITERS; i++) begin
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x -= dx;
            y += dy;
            z -= ARCTAN[i];
         end else begin
            x += dx;
            y -= dy;
            z += ARCTAN[i];
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      c = int'(clip(x, -longint'(TRIG_MAX), longint'(TRIG_MAX)));
      s = int'(clip(y, -longint'(TRIG_MAX), longint'(TRIG_MAX)));
   endfunction

   task automatic predict_world_command(input logic [11:0] roll, input logic [11:0] pitch,
                                        input logic [11:0] throttle, input logic [11:0] yaw,
                                        input logic load, input logic [15:0] hdg);
      rsp_type e;
      longint r, p, t, w, vx, vy, vz, rate, wx, wy;
      int c, s;
      r = centered(roll);
      p = centered(pitch);
      t = centered(throttle);
      w = centered(yaw);
      if (load) heading_now = longint'(hdg) & ANGLE_MASK;
      vx = (p * longint'(settings.vel_forward_max)) / STICK_HALF;
      vy = -((r * longint'(settings.vel_lateral_max)) / STICK_HALF);
      vz = (t * longint'(settings.vel_vertical_max)) / STICK_HALF;
      if (!settings.auto_yaw)
         heading_now = (heading_now + (w * longint'(settings.heading_gain)) / GAIN_DIV)
                       & ANGLE_MASK;
      rate = (w * longint'(settings.rate_gain)) / GAIN_DIV;
      heading_trig(heading_now, c, s);
      wx = (longint'(c) * vx - longint'(s) * vy + 16384) >>> 15;
      wy = (longint'(s) * vx + longint'(c) * vy + 16384) >>> 15;
      e.vel_world_x  = 17'(clip(wx, -65536, 65535));
      e.vel_world_y  = 17'(clip(wy, -65536, 65535));
      e.vel_world_z  = 16'(clip(vz, -32768, 32767));
      e.yaw_rate_cmd = 16'(clip(rate, -32768, 32767));
      e.heading_out  = 16'(heading_now);
      velocity_expected.push_back(e);
   endtask

   task automatic report_mismatch(string msg);
      $display("[%0t] velocity command %0d: %s", $time, checked, msg);
      fail_count++;
   endtask

   task automatic compare_field(string name, logic [16:0] got, logic [16:0] want);
      if (got !== want) report_mismatch($sformatf("%s got %h expected %h", name, got, want));
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         settings = CFG_RESET;
         heading_now = 0;
         velocity_expected.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            written++;
            case (csr_index)
               REG_VEL_FORWARD_MAX:  settings.vel_forward_max  = csr_data[14:0];
               REG_VEL_LATERAL_MAX:  settings.vel_lateral_max  = csr_data[14:0];
               REG_VEL_VERTICAL_MAX: settings.vel_vertical_max = csr_data[14:0];
               REG_HEADING_GAIN:     settings.heading_gain     = csr_data[15:0];
               REG_RATE_GAIN:        settings.rate_gain        = csr_data[15:0];
               REG_AUTO_YAW:         settings.auto_yaw         = csr_data[0];
               default: ;
            endcase
         end
         if (push && !full) begin
            accepted++;
            predict_world_command(req_roll_stick, req_pitch_stick, req_throttle_stick,
                                  req_yaw_stick, req_load_heading, req_heading_in);
         end
         if (pop && !empty) begin
            if (velocity_expected.size() == 0) begin
               report_mismatch("result beat with no command outstanding");
            end else begin
               want = velocity_expected.pop_front();
               compare_field("vel_world_x", rsp_vel_world_x, want.vel_world_x);
               compare_field("vel_world_y", rsp_vel_world_y, want.vel_world_y);
               compare_field("vel_world_z", rsp_vel_world_z, want.vel_world_z);
               compare_field("yaw_rate_cmd", rsp_yaw_rate_cmd, want.yaw_rate_cmd);
               compare_field("heading_out", rsp_heading_out, want.heading_out);
            end
            checked++;
         end
      end
      mismatches      <= fail_count;
      outstanding     <= velocity_expected.size();
      commands_seen   <= accepted;
      results_checked <= checked;
      writes_seen     <= written;
   end

endmodule

>>> dv/testbench.sv
// stimulus and verdict for the stick to world velocity command unit
module testbench;
   import stsc_pkg::*;

   localparam int LIMIT = 500000;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  push = 1'b0;
   logic                  full;
   logic [11:0]           req_roll_stick = '0;
   logic [11:0]           req_pitch_stick = '0;
   logic [11:0]           req_throttle_stick = '0;
   logic [11:0]           req_yaw_stick = '0;
   logic                  req_load_heading = 1'b0;
   logic [15:0]           req_heading_in = '0;
   logic                  empty;
   logic                  pop = 1'b0;
   logic signed [16:0]    rsp_vel_world_x;
   logic signed [16:0]    rsp_vel_world_y;
   logic signed [15:0]    rsp_vel_world_z;
   logic signed [15:0]    rsp_yaw_rate_cmd;
   logic [15:0]           rsp_heading_out;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   int mismatches, outstanding, commands_seen, results_checked, writes_seen;
   int cycles = 0;
   int settings_used = 0;
   bit steady = 1'b0;

   stick_to_world_velocity_command_unit dut (.*);
   velocity_command_checker scoreboard (.*);

   always #5 clock = ~clock;

   always @(posedge clock) pop <= steady || ($urandom_range(99) >= 14);

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("timeout after %0d cycles with %0d results outstanding", cycles, outstanding);
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic send_command(logic [11:0] roll, logic [11:0] pitch, logic [11:0] throttle,
                               logic [11:0] yaw, logic load, logic [15:0] hdg);
      if (!steady && $urandom_range(99) < 14) begin
         push <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < 40);
      end
      push               <= 1'b1;
      req_roll_stick     <= roll;
      req_pitch_stick    <= pitch;
      req_throttle_stick <= throttle;
      req_yaw_stick      <= yaw;
      req_load_heading   <= load;
      req_heading_in     <= hdg;
      do @(posedge clock); while (full);
   endtask

   task automatic wait_idle();
      push <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_IDX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // spare upper bits carry random junk that must be masked off
   task automatic apply_settings(cfg_type c);
      write_register(REG_VEL_FORWARD_MAX, {1'($urandom), c.vel_forward_max});
      write_register(REG_VEL_LATERAL_MAX, {1'($urandom), c.vel_lateral_max});
      write_register(REG_VEL_VERTICAL_MAX, {1'($urandom), c.vel_vertical_max});
      write_register(REG_HEADING_GAIN, c.heading_gain);
      write_register(REG_RATE_GAIN, c.rate_gain);
      write_register(REG_AUTO_YAW, {15'($urandom), c.auto_yaw});
      write_register($urandom_range(1) ? REG_UNUSED_HI : REG_UNUSED_LO, 16'($urandom));
      settings_used++;
   endtask

   function automatic logic [11:0] random_stick();
      int pick;
      pick = $urandom_range(99);
      if (pick < 15) return 12'($urandom);
      if (pick < 20) return 12'd1000;
      if (pick < 25) return 12'd2000;
      if (pick < 28) return 12'd1500;
      return 12'($urandom_range(2050, 950));
   endfunction

   task automatic send_random();
      send_command(random_stick(), random_stick(), random_stick(), random_stick(),
                   $urandom_range(9) == 0, 16'($urandom));
   endtask

   initial begin
      cfg_type c;
      int p, i;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults after reset: clamp edges, heading loads and the fold boundaries
      send_command(12'd1500, 12'd1500, 12'd1500, 12'd1500, 1'b0, 16'h0000);
      send_command(12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 16'h2000);
      send_command(12'd4095, 12'd4095, 12'd4095, 12'd4095, 1'b0, 16'h0000);
      send_command(12'd999, 12'd2001, 12'd1000, 12'd2000, 1'b1, 16'h4000);
      send_command(12'd2000, 12'd1000, 12'd2000, 12'd1000, 1'b1, 16'h4001);
      send_command(12'd1000, 12'd2000, 12'd1000, 12'd2000, 1'b1, 16'hC000);
      send_command(12'd1500, 12'd2000, 12'd1500, 12'd1500, 1'b1, 16'hBFFF);
      send_command(12'd2000, 12'd2000, 12'd2000, 12'd2000, 1'b1, 16'h8000);
      send_command(12'd1000, 12'd1000, 12'd1000, 12'd1000, 1'b1, 16'hFFFF);
      send_command(12'hAAA, 12'h555, 12'd1234, 12'd1766, 1'b1, 16'h5555);
      send_command(12'h555, 12'hAAA, 12'd1766, 12'd1234, 1'b1, 16'hAAAA);
      wait_idle();

      // heading integration at full gains, wrapping both ways
      c = CFG_RESET;
      c.auto_yaw = 1'b0;
      c.heading_gain = 16'hFFFF;
      c.rate_gain = 16'hFFFF;
      apply_settings(c);
      send_command(12'd1500, 12'd2000, 12'd1500, 12'd2000, 1'b1, 16'h0000);
      send_command(12'd1500, 12'd2000, 12'd1500, 12'd2000, 1'b0, 16'h0000);
      send_command(12'd1500, 12'd2000, 12'd1500, 12'd4095, 1'b0, 16'h0000);
      send_command(12'd1500, 12'd2000, 12'd1500, 12'd1000, 1'b1, 16'h0000);
      send_command(12'd1500, 12'd2000, 12'd1500, 12'd0, 1'b0, 16'h0000);
      send_command(12'd2000, 12'd1500, 12'd1500, 12'd1501, 1'b0, 16'h0000);
      send_command(12'd2000, 12'd1500, 12'd1500, 12'd1499, 1'b1, 16'hFFFF);
      wait_idle();

      for (p = 0; p < 7; p++) begin
         case (p)
            0: c = CFG_RESET;
            1: c = '{vel_forward_max: 15'h7FFF, vel_lateral_max: 15'h7FFF,
                     vel_vertical_max: 15'h7FFF, heading_gain: 16'hFFFF,
                     rate_gain: 16'hFFFF, auto_yaw: 1'b0};
            2: c = '{vel_forward_max: 15'h0, vel_lateral_max: 15'h0,
                     vel_vertical_max: 15'h0, heading_gain: 16'h0,
                     rate_gain: 16'h0, auto_yaw: 1'b0};
            default: begin
               c.vel_forward_max  = 15'($urandom);
               c.vel_lateral_max  = 15'($urandom);
               c.vel_vertical_max = 15'($urandom);
               c.heading_gain     = 16'($urandom);
               c.rate_gain        = 16'($urandom);
               c.auto_yaw         = ($urandom_range(3) == 0);
            end
         endcase
         steady <= (p == 3);
         apply_settings(c);
         for (i = 0; i < 200; i++) begin
            if (p == 4 && i == 100) wait_idle();
            send_random();
         end
         wait_idle();
      end

      $display("covered %0d commands and %0d results over %0d register settings",
               commands_seen, results_checked, settings_used);
      $display("%0d register writes including unused indexes and masked upper bits",
               writes_seen);
      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule
